FILE: hdl/lbbcd_pkg.sv
// package: shared constants and types of the cache directory
`default_nettype none
package lbbcd_pkg;
  localparam int unsigned ENTRIES_DEF    = 32;
  localparam int unsigned STAMP_BITS_DEF = 40;
  localparam int unsigned KEY_W    = 18;
  localparam int unsigned SIZE_W   = 32;
  localparam int unsigned BUDGET_W = 40;
  localparam int unsigned USED_W   = 41;
  localparam int unsigned CNT_W    = 40;
  localparam int unsigned SLOT_W   = 5;
  localparam int unsigned EVC_W    = 6;
  localparam logic [BUDGET_W-1:0] BUDGET_RESET = 40'd67108864;

  typedef enum logic [0:0] {
    FUNC_LOOKUP = 1'b0,
    FUNC_INSERT = 1'b1
  } func_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_EVICT,
    ST_WRITE,
    ST_OUT
  } state_e;
endpackage
`default_nettype wire

FILE: hdl/lbbcd_if.sv
// handshake channel interfaces
`default_nettype none
interface lbbcd_req_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [7:0]  layer_index;
  logic [1:0]  tensor_kind;
  logic [7:0]  expert_id;
  logic [31:0] entry_size;
  modport source (output valid, func, layer_index, tensor_kind, expert_id, entry_size,
                  input ready);
  modport sink (input valid, func, layer_index, tensor_kind, expert_id, entry_size,
                output ready);
endinterface

interface lbbcd_rsp_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic        already_present;
  logic [4:0]  slot;
  logic [5:0]  evicted_count;
  logic [40:0] bytes_in_use;
  logic [39:0] hit_count;
  logic [39:0] miss_count;
  modport source (output valid, hit, already_present, slot, evicted_count, bytes_in_use,
                  hit_count, miss_count, input ready);
  modport sink (input valid, hit, already_present, slot, evicted_count, bytes_in_use,
                hit_count, miss_count, output ready);
endinterface

interface lbbcd_cfg_if;
  logic        valid;
  logic        ready;
  logic [39:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

FILE: hdl/lbbcd_cell.sv
// one directory slot; takes part in a rippling min-stamp, key-match and free-slot chain
`default_nettype none
module lbbcd_cell #(
  parameter int unsigned STAMP_BITS = lbbcd_pkg::STAMP_BITS_DEF,
  parameter int unsigned IDX_W      = 5
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [IDX_W-1:0]              my_idx_i,
  // chain in from lower neighbour (registered there)
  input  wire logic                          c_found_i,
  input  wire logic [IDX_W-1:0]              c_found_idx_i,
  input  wire logic                          c_min_vld_i,
  input  wire logic [STAMP_BITS-1:0]         c_min_stamp_i,
  input  wire logic [IDX_W-1:0]              c_min_idx_i,
  input  wire logic [lbbcd_pkg::SIZE_W-1:0]  c_min_size_i,
  input  wire logic                          c_free_vld_i,
  input  wire logic [IDX_W-1:0]              c_free_idx_i,
  // chain out, registered
  output logic                               c_found_o,
  output logic [IDX_W-1:0]                   c_found_idx_o,
  output logic                               c_min_vld_o,
  output logic [STAMP_BITS-1:0]              c_min_stamp_o,
  output logic [IDX_W-1:0]                   c_min_idx_o,
  output logic [lbbcd_pkg::SIZE_W-1:0]       c_min_size_o,
  output logic                               c_free_vld_o,
  output logic [IDX_W-1:0]                   c_free_idx_o,
  // broadcast control
  input  wire logic [lbbcd_pkg::KEY_W-1:0]   key_i,
  input  wire logic                          clr_i,
  input  wire logic                          wr_i,
  input  wire logic                          stamp_wr_i,
  input  wire logic [lbbcd_pkg::SIZE_W-1:0]  size_i,
  input  wire logic [STAMP_BITS-1:0]         stamp_i,
  output logic                               valid_o
);
  logic                          valid_q;
  logic [lbbcd_pkg::KEY_W-1:0]   key_q;
  logic [lbbcd_pkg::SIZE_W-1:0]  size_q;
  logic [STAMP_BITS-1:0]         stamp_q;
  logic                          take_min;

  assign valid_o  = valid_q;
  // strict compare keeps the lowest slot on a tie
  assign take_min = valid_q && (!c_min_vld_i || stamp_q < c_min_stamp_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (clr_i) begin
      valid_q <= 1'b0;
    end else if (wr_i) begin
      valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      key_q  <= key_i;
      size_q <= size_i;
    end
    if (wr_i || stamp_wr_i) begin
      stamp_q <= stamp_i;
    end
    c_found_o     <= c_found_i || (valid_q && key_q == key_i);
    c_found_idx_o <= c_found_i ? c_found_idx_i : my_idx_i;
    c_min_vld_o   <= c_min_vld_i || valid_q;
    c_min_stamp_o <= take_min ? stamp_q : c_min_stamp_i;
    c_min_idx_o   <= take_min ? my_idx_i : c_min_idx_i;
    c_min_size_o  <= take_min ? size_q : c_min_size_i;
    c_free_vld_o  <= c_free_vld_i || !valid_q;
    c_free_idx_o  <= c_free_vld_i ? c_free_idx_i : my_idx_i;
  end
endmodule
`default_nettype wire

FILE: hdl/lru_byte_budget_cache_directory_unit.sv
// top level: lru directory with byte budget built from a chain of slot cells
//
//  channel  | dir  | contents
//  req      | in   | func, layer_index, tensor_kind, expert_id, entry_size
//  rsp      | out  | hit, already_present, slot, evicted_count, bytes_in_use, counts
//  cfg      | in   | byte_budget write data
//
// each chain pass ripples through the cells, one cell per cycle, and is followed by a decide
// step; a lookup or a present insert goes scan, decide, out, and a fresh insert adds a write
// step before out plus, per eviction, an evict, a rescan and a decide
// reset clears all slot valid bits, counters and the budget to its reset value
// the result sits in an output register; a stalled rsp holds the block until taken
`default_nettype none
module lru_byte_budget_cache_directory_unit #(
  parameter int unsigned ENTRIES    = lbbcd_pkg::ENTRIES_DEF,
  parameter int unsigned STAMP_BITS = lbbcd_pkg::STAMP_BITS_DEF
) (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  lbbcd_req_if.sink   req,
  lbbcd_rsp_if.source rsp,
  lbbcd_cfg_if.sink   cfg
);
  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW    = $clog2(ENTRIES + 2);
  localparam logic [STAMP_BITS-1:0] STAMP_MAX = '1;
  localparam logic [lbbcd_pkg::CNT_W-1:0] CNT_MAX = '1;

  lbbcd_pkg::state_e state_q, state_d;

  // captured request and directory state
  logic                           func_q;
  logic [lbbcd_pkg::KEY_W-1:0]    key_q;
  logic [lbbcd_pkg::SIZE_W-1:0]   size_q;
  logic [lbbcd_pkg::BUDGET_W-1:0] budget_q;
  logic [lbbcd_pkg::USED_W-1:0]   used_q, used_d;
  logic [STAMP_BITS-1:0]          stamp_cnt_q, stamp_cnt_d;
  logic [lbbcd_pkg::CNT_W-1:0]    hits_q, hits_d, miss_q, miss_d;
  logic [CW-1:0]                  cyc_q, cyc_d;
  logic [lbbcd_pkg::EVC_W-1:0]    evc_q, evc_d;
  logic                           first_q, first_d;

  // output register
  logic                           o_vld_q;
  logic                           o_hit_q, o_pres_q;
  logic [lbbcd_pkg::SLOT_W-1:0]   o_slot_q;
  logic                           o_load;
  logic                           o_hit_d, o_pres_d;
  logic [lbbcd_pkg::SLOT_W-1:0]   o_slot_d;

  // chain wiring, element i feeds cell i
  logic                          ch_found   [ENTRIES+1];
  logic [IDX_W-1:0]              ch_fidx    [ENTRIES+1];
  logic                          ch_mvld    [ENTRIES+1];
  logic [STAMP_BITS-1:0]         ch_mstamp  [ENTRIES+1];
  logic [IDX_W-1:0]              ch_midx    [ENTRIES+1];
  logic [lbbcd_pkg::SIZE_W-1:0]  ch_msize   [ENTRIES+1];
  logic                          ch_fvld    [ENTRIES+1];
  logic [IDX_W-1:0]              ch_fridx   [ENTRIES+1];
  logic [ENTRIES-1:0]            valid_v;

  // per-cell controls
  logic              do_clr, do_wr, do_stamp;
  logic [IDX_W-1:0]  tgt_idx;
  logic [STAMP_BITS-1:0] stamp_bc;

  assign ch_found[0]  = 1'b0;
  assign ch_fidx[0]   = '0;
  assign ch_mvld[0]   = 1'b0;
  assign ch_mstamp[0] = '0;
  assign ch_midx[0]   = '0;
  assign ch_msize[0]  = '0;
  assign ch_fvld[0]   = 1'b0;
  assign ch_fridx[0]  = '0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    lbbcd_cell #(.STAMP_BITS(STAMP_BITS), .IDX_W(IDX_W)) u_cell (
      .clk_i, .rst_ni,
      .my_idx_i      (IDX_W'(g)),
      .c_found_i     (ch_found[g]),  .c_found_idx_i (ch_fidx[g]),
      .c_min_vld_i   (ch_mvld[g]),   .c_min_stamp_i (ch_mstamp[g]),
      .c_min_idx_i   (ch_midx[g]),   .c_min_size_i  (ch_msize[g]),
      .c_free_vld_i  (ch_fvld[g]),   .c_free_idx_i  (ch_fridx[g]),
      .c_found_o     (ch_found[g+1]), .c_found_idx_o (ch_fidx[g+1]),
      .c_min_vld_o   (ch_mvld[g+1]),  .c_min_stamp_o (ch_mstamp[g+1]),
      .c_min_idx_o   (ch_midx[g+1]),  .c_min_size_o  (ch_msize[g+1]),
      .c_free_vld_o  (ch_fvld[g+1]),  .c_free_idx_o  (ch_fridx[g+1]),
      .key_i         (key_q),
      .clr_i         (do_clr && tgt_idx == IDX_W'(g)),
      .wr_i          (do_wr && tgt_idx == IDX_W'(g)),
      .stamp_wr_i    (do_stamp && tgt_idx == IDX_W'(g)),
      .size_i        (size_q),
      .stamp_i       (stamp_bc),
      .valid_o       (valid_v[g])
    );
  end

  // chain results are stable once the pass has rippled through every cell
  logic                  r_found, r_mvld, r_fvld;
  logic [IDX_W-1:0]      r_fidx, r_midx, r_fridx;
  logic [lbbcd_pkg::SIZE_W-1:0] r_msize;
  logic                  over_budget, pass_done;
  assign r_found = ch_found[ENTRIES];
  assign r_fidx  = ch_fidx[ENTRIES];
  assign r_mvld  = ch_mvld[ENTRIES];
  assign r_midx  = ch_midx[ENTRIES];
  assign r_msize = ch_msize[ENTRIES];
  assign r_fvld  = ch_fvld[ENTRIES];
  assign r_fridx = ch_fridx[ENTRIES];
  assign pass_done = (cyc_q == CW'(ENTRIES));
  assign over_budget = (used_q + lbbcd_pkg::USED_W'(size_q))
                       > lbbcd_pkg::USED_W'(budget_q);
  assign stamp_bc = (stamp_cnt_q < STAMP_MAX) ? stamp_cnt_q + 1'b1 : stamp_cnt_q;

  assign req.ready = (state_q == lbbcd_pkg::ST_IDLE) && !o_vld_q;
  assign cfg.ready = 1'b1;

  always_comb begin
    state_d = state_q;
    cyc_d = cyc_q; evc_d = evc_q; first_d = first_q;
    used_d = used_q; stamp_cnt_d = stamp_cnt_q;
    hits_d = hits_q; miss_d = miss_q;
    do_clr = 1'b0; do_wr = 1'b0; do_stamp = 1'b0; tgt_idx = '0;
    o_load = 1'b0; o_hit_d = 1'b0; o_pres_d = 1'b0; o_slot_d = '0;
    unique case (state_q)
      lbbcd_pkg::ST_IDLE: begin
        if (req.valid && req.ready) begin
          state_d = lbbcd_pkg::ST_SCAN; cyc_d = '0; evc_d = '0; first_d = 1'b1;
        end
      end
      lbbcd_pkg::ST_SCAN: begin
        cyc_d = cyc_q + 1'b1;
        if (pass_done) begin
          cyc_d = '0;
          state_d = lbbcd_pkg::ST_DECIDE;
        end
      end
      lbbcd_pkg::ST_DECIDE: begin
        first_d = 1'b0;
        if (func_q == lbbcd_pkg::FUNC_LOOKUP) begin
          o_load = 1'b1;
          if (r_found) begin
            o_hit_d = 1'b1; o_slot_d = lbbcd_pkg::SLOT_W'(r_fidx);
            do_stamp = 1'b1; tgt_idx = r_fidx; stamp_cnt_d = stamp_bc;
            if (hits_q != CNT_MAX) hits_d = hits_q + 1'b1;
          end else if (miss_q != CNT_MAX) begin
            miss_d = miss_q + 1'b1;
          end
          state_d = lbbcd_pkg::ST_OUT;
        end else if (first_q && r_found) begin
          o_load = 1'b1; o_pres_d = 1'b1; o_slot_d = lbbcd_pkg::SLOT_W'(r_fidx);
          state_d = lbbcd_pkg::ST_OUT;
        end else if ((over_budget && r_mvld) || !r_fvld) begin
          state_d = lbbcd_pkg::ST_EVICT;
        end else begin
          state_d = lbbcd_pkg::ST_WRITE;
        end
      end
      lbbcd_pkg::ST_EVICT: begin
        do_clr = 1'b1; tgt_idx = r_midx;
        used_d = used_q - lbbcd_pkg::USED_W'(r_msize);
        evc_d = evc_q + 1'b1;
        state_d = lbbcd_pkg::ST_SCAN;
      end
      lbbcd_pkg::ST_WRITE: begin
        do_wr = 1'b1; tgt_idx = r_fridx; stamp_cnt_d = stamp_bc;
        used_d = used_q + lbbcd_pkg::USED_W'(size_q);
        o_load = 1'b1; o_slot_d = lbbcd_pkg::SLOT_W'(r_fridx);
        state_d = lbbcd_pkg::ST_OUT;
      end
      lbbcd_pkg::ST_OUT: begin
        if (rsp.ready) state_d = lbbcd_pkg::ST_IDLE;
      end
      default: state_d = lbbcd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lbbcd_pkg::ST_IDLE;
      budget_q <= lbbcd_pkg::BUDGET_RESET;
      used_q <= '0; stamp_cnt_q <= '0; hits_q <= '0; miss_q <= '0;
      cyc_q <= '0; evc_q <= '0; first_q <= 1'b0;
      o_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg.valid && cfg.ready) budget_q <= cfg.data;
      used_q <= used_d; stamp_cnt_q <= stamp_cnt_d;
      hits_q <= hits_d; miss_q <= miss_d;
      cyc_q <= cyc_d; evc_q <= evc_d; first_q <= first_d;
      if (o_load) o_vld_q <= 1'b1;
      else if (rsp.ready) o_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req.valid && req.ready) begin
      func_q <= req.func;
      key_q  <= {req.layer_index, req.tensor_kind, req.expert_id};
      size_q <= req.entry_size;
    end
    if (o_load) begin
      o_hit_q <= o_hit_d; o_pres_q <= o_pres_d; o_slot_q <= o_slot_d;
    end
  end

  // counters and sizes are read live: they settle with the output load
  assign rsp.valid           = o_vld_q;
  assign rsp.hit             = o_hit_q;
  assign rsp.already_present = o_pres_q;
  assign rsp.slot            = o_slot_q;
  assign rsp.evicted_count   = evc_q;
  assign rsp.bytes_in_use    = used_q;
  assign rsp.hit_count       = hits_q;
  assign rsp.miss_count      = miss_q;

  a_one_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(do_clr && do_wr)) else $error("evict and write in one cycle");
  a_out_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    o_vld_q |-> state_q == lbbcd_pkg::ST_OUT) else $error("result outside out state");
  a_evc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evc_q <= lbbcd_pkg::EVC_W'(ENTRIES)) else $error("too many evictions");
  a_evict_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == lbbcd_pkg::ST_EVICT |-> r_mvld) else $error("evict with no entry");
  a_write_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == lbbcd_pkg::ST_WRITE |-> !valid_v[r_fridx]) else $error("write to busy slot");
endmodule
`default_nettype wire

FILE: tb/sv/tb_lbbcd_if.sv
// testbench package: request and response row types of the directed table
package tb_lbbcd_pkg;
  typedef struct {
    logic        func;
    logic [7:0]  layer_index;
    logic [1:0]  tensor_kind;
    logic [7:0]  expert_id;
    logic [31:0] entry_size;
  } dir_req_t;

  typedef struct {
    logic        hit;
    logic        already_present;
    logic [4:0]  slot;
    logic [5:0]  evicted_count;
    logic [40:0] bytes_in_use;
    logic [39:0] hit_count;
    logic [39:0] miss_count;
  } dir_rsp_t;
endpackage

FILE: tb/sv/tb_lru_byte_budget_cache_directory_unit.sv
// testbench: cache directory checked against its own lru predictor under random flow control
module tb_lru_byte_budget_cache_directory_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_SLOTS = 32;
  localparam logic [39:0] MAX40 = 40'hFF_FFFF_FFFF;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  lbbcd_req_if req();
  lbbcd_rsp_if rsp();
  lbbcd_cfg_if cfg();

  lru_byte_budget_cache_directory_unit uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .req(req.sink), .rsp(rsp.source), .cfg(cfg.sink)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // predictor state, a private copy of the directory
  logic [39:0] budget_mdl;
  logic        live_mdl [N_SLOTS];
  logic [17:0] key_mdl  [N_SLOTS];
  logic [31:0] size_mdl [N_SLOTS];
  logic [39:0] age_mdl  [N_SLOTS];
  logic [40:0] used_mdl;
  logic [39:0] stamp_mdl;
  logic [39:0] hits_mdl;
  logic [39:0] misses_mdl;

  tb_lbbcd_pkg::dir_rsp_t pending_rsp_q[$];
  // answers of the directed rows, one per row whether typed in or not, in the order they are sent
  tb_lbbcd_pkg::dir_rsp_t typed_rsp_q[$];
  bit       typed_flag_q[$];
  int errors = 0;
  int n_rsp = 0;
  bit rsp_stall_on = 1'b1;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch on response %0d: %s got %0h expected %0h", n_rsp, what, got, want);
    errors++;
  endtask

  function automatic logic [39:0] bump_stamp();
    if (stamp_mdl != MAX40) stamp_mdl++;
    return stamp_mdl;
  endfunction

  // lowest stamp wins, ties to the lowest slot
  function automatic void drop_oldest();
    int victim;
    victim = -1;
    for (int i = 0; i < N_SLOTS; i++)
      if (live_mdl[i] && (victim < 0 || age_mdl[i] < age_mdl[victim])) victim = i;
    if (victim >= 0) begin
      used_mdl = used_mdl - 41'(size_mdl[victim]);
      live_mdl[victim] = 1'b0;
    end
  endfunction

  function automatic bit any_live();
    foreach (live_mdl[i]) if (live_mdl[i]) return 1'b1;
    return 1'b0;
  endfunction

  function automatic int lowest_free();
    foreach (live_mdl[i]) if (!live_mdl[i]) return i;
    return -1;
  endfunction

  function automatic tb_lbbcd_pkg::dir_rsp_t predict_directory(input tb_lbbcd_pkg::dir_req_t r);
    tb_lbbcd_pkg::dir_rsp_t o;
    logic [17:0] k;
    int idx, f;
    k = {r.layer_index, r.tensor_kind, r.expert_id};
    o = '{default: '0};
    idx = -1;
    for (int i = 0; i < N_SLOTS; i++)
      if (idx < 0 && live_mdl[i] && key_mdl[i] == k) idx = i;
    if (r.func == lbbcd_pkg::FUNC_LOOKUP) begin
      if (idx >= 0) begin
        o.hit = 1'b1;
        o.slot = 5'(idx);
        age_mdl[idx] = bump_stamp();
        if (hits_mdl != MAX40) hits_mdl++;
      end else if (misses_mdl != MAX40) misses_mdl++;
    end else if (idx >= 0) begin
      o.already_present = 1'b1;
      o.slot = 5'(idx);
    end else begin
      while ((42'(used_mdl) + 42'(r.entry_size)) > 42'(budget_mdl) && any_live()) begin
        drop_oldest();
        o.evicted_count++;
      end
      f = lowest_free();
      if (f < 0) begin
        drop_oldest();
        o.evicted_count++;
        f = lowest_free();
      end
      live_mdl[f] = 1'b1;
      key_mdl[f] = k;
      size_mdl[f] = r.entry_size;
      age_mdl[f] = bump_stamp();
      used_mdl = used_mdl + 41'(r.entry_size);
      o.slot = 5'(f);
    end
    o.bytes_in_use = used_mdl;
    o.hit_count = hits_mdl;
    o.miss_count = misses_mdl;
    return o;
  endfunction

  // sender side
  task automatic send_request(input tb_lbbcd_pkg::dir_req_t r);
    tb_lbbcd_pkg::dir_rsp_t e;
    req.valid <= 1'b1;
    req.func <= r.func;
    req.layer_index <= r.layer_index;
    req.tensor_kind <= r.tensor_kind;
    req.expert_id <= r.expert_id;
    req.entry_size <= r.entry_size;
    do @(posedge clk_i); while (!req.ready);
    e = predict_directory(r);
    pending_rsp_q = {pending_rsp_q, e};
  endtask

  // a zero-length gap leaves valid high so the next request follows directly
  task automatic idle_request(input int cycles);
    if (cycles > 0) begin
      req.valid <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    req.valid <= 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk_i);
    // let any trailing activity settle
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_budget(input logic [39:0] value);
    cfg.valid <= 1'b1;
    cfg.data <= value;
    do @(posedge clk_i); while (!cfg.ready);
    cfg.valid <= 1'b0;
    budget_mdl = value;
  endtask

  // keys mostly drawn from a small pool so that lookups hit and inserts repeat
  function automatic tb_lbbcd_pkg::dir_req_t random_request(input int pool,
                                                            input logic [31:0] size_cap);
    tb_lbbcd_pkg::dir_req_t r;
    int n;
    r.func = $urandom_range(1, 0) ? lbbcd_pkg::FUNC_INSERT : lbbcd_pkg::FUNC_LOOKUP;
    if ($urandom_range(9, 0) == 0) begin
      r.layer_index = 8'($urandom); r.tensor_kind = 2'($urandom); r.expert_id = 8'($urandom);
    end else begin
      n = $urandom_range(pool - 1, 0);
      r.layer_index = 8'(n * 37);
      r.tensor_kind = 2'(n >> 2);
      r.expert_id = 8'(n ^ 8'hA5);
    end
    case ($urandom_range(7, 0))
      0: r.entry_size = 32'hFFFF_FFFF;
      1: r.entry_size = '0;
      default: r.entry_size = $urandom_range(size_cap, 0);
    endcase
    return r;
  endfunction

  // directed table; an answer is typed in only where it is obvious
  tb_lbbcd_pkg::dir_req_t dir_tab[] = '{
    '{lbbcd_pkg::FUNC_LOOKUP, 8'h00, 2'd0, 8'h00, 32'd0},          // miss on empty table
    '{lbbcd_pkg::FUNC_INSERT, 8'h00, 2'd0, 8'h00, 32'd100},        // first insert, slot 0
    '{lbbcd_pkg::FUNC_INSERT, 8'h00, 2'd0, 8'h00, 32'd999},        // resident key
    '{lbbcd_pkg::FUNC_LOOKUP, 8'h00, 2'd0, 8'h00, 32'hFFFF_FFFF},  // hit
    '{lbbcd_pkg::FUNC_INSERT, 8'hFF, 2'd3, 8'hFF, 32'd1},          // kind 3 is its own key
    '{lbbcd_pkg::FUNC_LOOKUP, 8'hFF, 2'd2, 8'hFF, 32'd0},          // differs only in kind
    '{lbbcd_pkg::FUNC_INSERT, 8'hFF, 2'd2, 8'hFF, 32'hFFFF_FFFF},  // oversized, clears all
    '{lbbcd_pkg::FUNC_LOOKUP, 8'h00, 2'd0, 8'h00, 32'd0},
    '{lbbcd_pkg::FUNC_INSERT, 8'h55, 2'd1, 8'hAA, 32'h0400_0000},
    '{lbbcd_pkg::FUNC_INSERT, 8'hAA, 2'd2, 8'h55, 32'd0},
    '{lbbcd_pkg::FUNC_LOOKUP, 8'hFF, 2'd2, 8'hFF, 32'd0},
    '{lbbcd_pkg::FUNC_LOOKUP, 8'h55, 2'd1, 8'hAA, 32'd0},
    '{lbbcd_pkg::FUNC_INSERT, 8'h01, 2'd0, 8'h80, 32'h8000_0000}
  };
  bit dir_typed[] = '{1, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0};
  tb_lbbcd_pkg::dir_rsp_t dir_ans[] = '{
    '{1'b0, 1'b0, 5'd0, 6'd0, 41'd0,   40'd0, 40'd1},
    '{1'b0, 1'b0, 5'd0, 6'd0, 41'd100, 40'd0, 40'd1},
    '{1'b0, 1'b1, 5'd0, 6'd0, 41'd100, 40'd0, 40'd1},
    '{1'b1, 1'b0, 5'd0, 6'd0, 41'd100, 40'd1, 40'd1},
    '{default: '0}, '{default: '0}, '{default: '0}, '{default: '0}, '{default: '0},
    '{default: '0}, '{default: '0}, '{default: '0}, '{default: '0}
  };

  // receiver side: checks every response against the oldest expectation, or the typed-in answer of a directed row
  always @(posedge clk_i) begin
    tb_lbbcd_pkg::dir_rsp_t want;
    if (rst_ni && rsp.valid && rsp.ready) begin
      n_rsp++;
      if (pending_rsp_q.size() == 0) begin
        $display("unexpected response %0d with nothing outstanding", n_rsp);
        errors++;
      end else begin
        want = pending_rsp_q.pop_front();
        if (typed_flag_q.size() != 0) begin
          if (typed_flag_q.pop_front()) want = typed_rsp_q.pop_front();
          else void'(typed_rsp_q.pop_front());
        end
        if (rsp.hit !== want.hit)
          report_mismatch("hit", 64'(rsp.hit), 64'(want.hit));
        if (rsp.already_present !== want.already_present)
          report_mismatch("already_present", 64'(rsp.already_present),
                          64'(want.already_present));
        if (rsp.slot !== want.slot)
          report_mismatch("slot", 64'(rsp.slot), 64'(want.slot));
        if (rsp.evicted_count !== want.evicted_count)
          report_mismatch("evicted_count", 64'(rsp.evicted_count), 64'(want.evicted_count));
        if (rsp.bytes_in_use !== want.bytes_in_use)
          report_mismatch("bytes_in_use", 64'(rsp.bytes_in_use), 64'(want.bytes_in_use));
        if (rsp.hit_count !== want.hit_count)
          report_mismatch("hit_count", 64'(rsp.hit_count), 64'(want.hit_count));
        if (rsp.miss_count !== want.miss_count)
          report_mismatch("miss_count", 64'(rsp.miss_count), 64'(want.miss_count));
      end
    end
  end

  // receiver stall pattern: runs of stall and flow, sometimes no stalls at all
  initial begin
    int run;
    rsp.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      run = $urandom_range(60, 1);
      if (rsp_stall_on && $urandom_range(2, 0) == 0) begin
        rsp.ready <= 1'b0;
        repeat ($urandom_range(70, 1)) @(posedge clk_i);
      end
      rsp.ready <= 1'b1;
      repeat (run) @(posedge clk_i);
    end
  end

  // run limit: about 1300 items, each with all its eviction passes, finish well under this
  initial begin
    #200ms;
    $display("simulation failed");
    $finish;
  end

  initial begin
    logic [39:0] budgets[] = '{40'd0, 40'd5000, 40'h00_FFFF_FFFF, MAX40, 40'd300000};
    int burst;
    req.valid <= 1'b0;
    req.func <= lbbcd_pkg::FUNC_LOOKUP;
    req.layer_index <= '0;
    req.tensor_kind <= '0;
    req.expert_id <= '0;
    req.entry_size <= '0;
    cfg.valid <= 1'b0;
    cfg.data <= '0;
    budget_mdl = lbbcd_pkg::BUDGET_RESET;
    foreach (live_mdl[i]) begin
      live_mdl[i] = 1'b0; key_mdl[i] = '0; size_mdl[i] = '0; age_mdl[i] = '0;
    end
    used_mdl = '0; stamp_mdl = '0; hits_mdl = '0; misses_mdl = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows at the reset budget
    foreach (dir_tab[i]) begin
      typed_flag_q = {typed_flag_q, dir_typed[i]};
      typed_rsp_q = {typed_rsp_q, dir_ans[i]};
      send_request(dir_tab[i]);
      if ($urandom_range(1, 0)) idle_request($urandom_range(4, 1));
    end
    drain_results();
    typed_flag_q.delete();
    typed_rsp_q.delete();

    // random phases, one per budget setting; small budgets force eviction chains
    foreach (budgets[p]) begin
      write_budget(budgets[p]);
      rsp_stall_on = (p != 2);
      for (int n = 0; n < 260; ) begin
        burst = $urandom_range(20, 1);
        for (int b = 0; b < burst && n < 260; b++, n++)
          send_request(random_request(p == 3 ? 48 : 40,
                                      (p == 1 || p == 4) ? 32'd3000 : 32'hFFFF_FFFF));
        if (n == 130) drain_results();
        else idle_request($urandom_range(12, 0));
      end
      drain_results();
    end

    // back to the reset value so both directions of every budget bit are covered
    write_budget(lbbcd_pkg::BUDGET_RESET);
    drain_results();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
